FILE: design/shell_command_line_lexer_unit_assert.svh
// ----------------------------------------------------------------------------
// Shell command line lexer assertion macros
// Clocked property shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LINE_LEXER_UNIT_ASSERT_SVH
`define SHELL_COMMAND_LINE_LEXER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SLCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/slcl_pkg.sv
// ----------------------------------------------------------------------------
// Shell command line lexer package
// Widths, codes, result types and helpers shared by the lexer modules.
// ----------------------------------------------------------------------------
package slcl_pkg;

  localparam int MAX_LINE    = 4096;
  localparam int POS_W       = $clog2(MAX_LINE + 1);
  localparam int START_W     = 12;
  localparam int LEN_W       = 13;
  localparam int RES_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QUOTE = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [START_W-1:0] tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic               is_end;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    result_t [RES_SLOTS-1:0] res;
    logic [1:0]              count;
  } bundle_t;

  function automatic result_t make_tok(pos_t start, pos_t len, logic is_end,
                                       logic [1:0] status);
    logic [POS_W+START_W-1:0] s_wide;
    logic [POS_W+LEN_W-1:0]   l_wide;
    result_t r;
    s_wide = {{START_W{1'b0}}, start};
    l_wide = {{LEN_W{1'b0}}, len};
    r.tok_start = s_wide[START_W-1:0];
    r.tok_len   = l_wide[LEN_W-1:0];
    r.is_end    = is_end;
    r.status    = status;
    return r;
  endfunction

endpackage

FILE: design/slcl_queue.sv
// ----------------------------------------------------------------------------
// Lexer result queue
// Small FIFO of result bundles between the classifier and the emitter.
// ----------------------------------------------------------------------------
module slcl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slcl_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output slcl_pkg::bundle_t pop_data,
  output logic              empty
);

  slcl_pkg::bundle_t               mem [slcl_pkg::QUEUE_DEPTH];
  logic [slcl_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [slcl_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [slcl_pkg::QUEUE_AW:0]     count;

  assign full     = (count == (slcl_pkg::QUEUE_AW + 1)'(slcl_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + slcl_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + slcl_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (slcl_pkg::QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (slcl_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/slcl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts one byte per cycle while the queue is not full, tracks word, quote
// and operator state, and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module slcl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              ch_valid,
  output logic              ch_ready,
  input  logic [7:0]        ch,
  input  logic              full,
  output logic              push,
  output slcl_pkg::bundle_t push_data
);

  typedef enum logic [1:0] {Q_NONE, Q_SINGLE, Q_DOUBLE} quote_t;
  typedef enum logic [1:0] {OP_NONE, OP_LESS, OP_GREATER} op_t;

  localparam slcl_pkg::pos_t MAX_POS = slcl_pkg::POS_W'(slcl_pkg::MAX_LINE);
  localparam slcl_pkg::pos_t ONE     = slcl_pkg::POS_W'(1);
  localparam slcl_pkg::pos_t TWO     = slcl_pkg::POS_W'(2);

  slcl_pkg::pos_t position, position_next;
  slcl_pkg::pos_t word_length, word_length_next;
  quote_t         quote_kind, quote_kind_next;
  op_t            pending, pending_next;
  logic           overflow, overflow_next;

  slcl_pkg::bundle_t bundle;
  logic [1:0]        n;
  logic [1:0]        end_status;
  logic              done;
  logic [7:0]        held;
  logic [7:0]        closer;
  logic              accept;

  assign ch_ready  = !full;
  assign accept    = ch_valid && ch_ready;
  assign push      = accept && (n != 2'd0);
  assign push_data = bundle;

  always_comb begin
    position_next    = position;
    word_length_next = word_length;
    quote_kind_next  = quote_kind;
    pending_next     = pending;
    overflow_next    = overflow;
    bundle           = '0;
    n                = 2'd0;
    end_status       = slcl_pkg::ST_OK;
    done             = 1'b0;
    held             = (pending == OP_LESS) ? slcl_pkg::CH_LESS : slcl_pkg::CH_GREAT;
    closer           = (quote_kind == Q_SINGLE) ? slcl_pkg::CH_SQUOTE : slcl_pkg::CH_DQUOTE;

    if (ch == slcl_pkg::CH_NUL) begin
      if (pending != OP_NONE) begin
        bundle.res[n] = slcl_pkg::make_tok(position - ONE, ONE, 1'b0, slcl_pkg::ST_OK);
        n = n + 2'd1;
      end
      if (quote_kind != Q_NONE) begin
        end_status = slcl_pkg::ST_QUOTE;
      end else if (word_length != '0) begin
        bundle.res[n] = slcl_pkg::make_tok(position - word_length, word_length, 1'b0,
                                           slcl_pkg::ST_OK);
        n = n + 2'd1;
      end
      if (overflow) begin
        end_status = slcl_pkg::ST_LONG;
      end
      bundle.res[n] = slcl_pkg::make_tok('0, '0, 1'b1, end_status);
      n = n + 2'd1;
      position_next    = '0;
      word_length_next = '0;
      quote_kind_next  = Q_NONE;
      pending_next     = OP_NONE;
      overflow_next    = 1'b0;
    end else if (position >= MAX_POS) begin
      overflow_next = 1'b1;
    end else begin
      if (pending != OP_NONE) begin
        pending_next = OP_NONE;
        if (ch == held) begin
          bundle.res[n] = slcl_pkg::make_tok(position - ONE, TWO, 1'b0, slcl_pkg::ST_OK);
          done = 1'b1;
        end else begin
          bundle.res[n] = slcl_pkg::make_tok(position - ONE, ONE, 1'b0, slcl_pkg::ST_OK);
        end
        n = n + 2'd1;
      end
      if (!done) begin
        if (quote_kind != Q_NONE) begin
          word_length_next = word_length + ONE;
          if (ch == closer) begin
            quote_kind_next = Q_NONE;
          end
        end else if (ch == slcl_pkg::CH_SPACE || ch == slcl_pkg::CH_TAB ||
                     ch == slcl_pkg::CH_PIPE || ch == slcl_pkg::CH_LESS ||
                     ch == slcl_pkg::CH_GREAT) begin
          if (word_length != '0) begin
            bundle.res[n] = slcl_pkg::make_tok(position - word_length, word_length, 1'b0,
                                               slcl_pkg::ST_OK);
            n = n + 2'd1;
            word_length_next = '0;
          end
          if (ch == slcl_pkg::CH_PIPE) begin
            bundle.res[n] = slcl_pkg::make_tok(position, ONE, 1'b0, slcl_pkg::ST_OK);
            n = n + 2'd1;
          end else if (ch == slcl_pkg::CH_LESS) begin
            pending_next = OP_LESS;
          end else if (ch == slcl_pkg::CH_GREAT) begin
            pending_next = OP_GREATER;
          end
        end else begin
          word_length_next = word_length + ONE;
          if (ch == slcl_pkg::CH_SQUOTE) begin
            quote_kind_next = Q_SINGLE;
          end else if (ch == slcl_pkg::CH_DQUOTE) begin
            quote_kind_next = Q_DOUBLE;
          end
        end
      end
      position_next = position + ONE;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      word_length <= '0;
      quote_kind  <= Q_NONE;
      pending     <= OP_NONE;
      overflow    <= 1'b0;
    end else if (accept) begin
      position    <= position_next;
      word_length <= word_length_next;
      quote_kind  <= quote_kind_next;
      pending     <= pending_next;
      overflow    <= overflow_next;
    end
  end

endmodule

FILE: design/slcl_back.sv
// ----------------------------------------------------------------------------
// Lexer back end
// Unpacks queued bundles into single results through an output register,
// one per cycle unless the receiver stalls with res_ready low.
// ----------------------------------------------------------------------------
module slcl_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  slcl_pkg::bundle_t                 head,
  output logic                              pop,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [slcl_pkg::START_W-1:0]      tok_start,
  output logic [slcl_pkg::LEN_W-1:0]        tok_len,
  output logic                              is_end,
  output logic [1:0]                        status,
  output logic                              last
);

  logic [1:0]        sel;
  logic              load;
  logic              last_slot;
  slcl_pkg::result_t cur;

  assign load      = !empty && (!res_valid || res_ready);
  assign last_slot = (sel == head.count - 2'd1);
  assign pop       = load && last_slot;
  assign cur       = head.res[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sel       <= 2'd0;
    end else if (load) begin
      res_valid <= 1'b1;
      sel       <= last_slot ? 2'd0 : sel + 2'd1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_start <= cur.tok_start;
      tok_len   <= cur.tok_len;
      is_end    <= cur.is_end;
      status    <= cur.status;
      last      <= last_slot;
    end
  end

endmodule

FILE: design/shell_command_line_lexer_unit.sv
// ----------------------------------------------------------------------------
// Shell command line lexer
// Splits a zero-terminated command line into word and operator tokens
// given as offset and length, then an end-of-line result with a status.
//
//   channel  direction  handshake              payload
//   ch       in         ch_valid / ch_ready    ch
//   res      out        res_valid / res_ready  tok_start tok_len is_end status last
//
// One byte is accepted per cycle while the 4-entry bundle queue has room.
// Results leave one per cycle from the output register unless res_ready stalls
// them; a byte that causes more than one result holds its queue entry until the
// last is loaded. A byte's results pass the bundle queue, then the output register.
// Reset is synchronous, with no clearing pass. Either side may stall independently.
// ----------------------------------------------------------------------------
module shell_command_line_lexer_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ch_valid,
  output logic                         ch_ready,
  input  logic [7:0]                   ch,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [slcl_pkg::START_W-1:0] tok_start,
  output logic [slcl_pkg::LEN_W-1:0]   tok_len,
  output logic                         is_end,
  output logic [1:0]                   status,
  output logic                         last
);

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  slcl_pkg::bundle_t push_data;
  slcl_pkg::bundle_t head;

  slcl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch_ready  (ch_ready),
    .ch        (ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  slcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  slcl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .tok_start (tok_start),
    .tok_len   (tok_len),
    .is_end    (is_end),
    .status    (status),
    .last      (last)
  );

endmodule

FILE: design/slcl_checker.sv
// ----------------------------------------------------------------------------
// Shell command line lexer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "shell_command_line_lexer_unit_assert.svh"

module slcl_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ch_valid,
  input  logic                         ch_ready,
  input  logic [7:0]                   ch,
  input  logic                         res_valid,
  input  logic                         res_ready,
  input  logic [slcl_pkg::START_W-1:0] tok_start,
  input  logic [slcl_pkg::LEN_W-1:0]   tok_len,
  input  logic                         is_end,
  input  logic [1:0]                   status,
  input  logic                         last
);

  `SLCL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(tok_start) && $stable(tok_len) && $stable(is_end) && $stable(status) && $stable(last), "result changed while stalled")
  `SLCL_ASSERT_SAME(a_end_shape, res_valid && is_end, tok_start == '0 && tok_len == '0 && last, "malformed end-of-line transaction")
  `SLCL_ASSERT_SAME(a_tok_shape, res_valid && !is_end, status == slcl_pkg::ST_OK && tok_len != '0, "malformed token transaction")
  `SLCL_ASSERT_SAME(a_status_code, res_valid, status == slcl_pkg::ST_OK || status == slcl_pkg::ST_QUOTE || status == slcl_pkg::ST_LONG, "undefined status code")

endmodule

bind shell_command_line_lexer_unit slcl_checker u_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell command line lexer testbench
// Feeds command lines byte by byte over the ch channel. A directed table
// comes first, then random lines built from words, blanks, operators and
// quoted strings. Each transaction on res is checked field by field against
// an in-bench tokenizer or, for typed rows, the directed table. Sender gaps and
// receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import slcl_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 336;

  typedef enum logic [1:0] {QK_NONE, QK_SINGLE, QK_DOUBLE} quote_e;
  typedef enum logic [1:0] {HOLD_NONE, HOLD_LESS, HOLD_GREAT} held_op_e;
  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} pace_e;

  typedef struct packed {
    logic [START_W-1:0] tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic               is_end;
    logic [1:0]         status;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] status;
  } stim_row_t;

  // typed rows must give exactly one end transaction with the given status
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{CH_NUL,    1'b1, ST_OK},
    '{CH_SQUOTE, 1'b0, ST_OK},
    '{CH_DQUOTE, 1'b0, ST_OK},
    '{CH_NUL,    1'b1, ST_QUOTE},
    '{CH_LESS,   1'b0, ST_OK},
    '{CH_GREAT,  1'b0, ST_OK},
    '{CH_LESS,   1'b0, ST_OK},
    '{CH_LESS,   1'b0, ST_OK},
    '{CH_LESS,   1'b0, ST_OK},
    '{CH_GREAT,  1'b0, ST_OK},
    '{CH_GREAT,  1'b0, ST_OK},
    '{CH_PIPE,   1'b0, ST_OK},
    '{8'hFF,     1'b0, ST_OK},
    '{CH_TAB,    1'b0, ST_OK},
    '{CH_DQUOTE, 1'b0, ST_OK},
    '{CH_SQUOTE, 1'b0, ST_OK},
    '{CH_SPACE,  1'b0, ST_OK},
    '{CH_DQUOTE, 1'b0, ST_OK},
    '{8'h01,     1'b0, ST_OK},
    '{CH_NUL,    1'b0, ST_OK},
    '{CH_GREAT,  1'b0, ST_OK},
    '{CH_NUL,    1'b0, ST_OK}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               ch_valid = 1'b0;
  logic               ch_ready;
  logic [7:0]         ch = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [START_W-1:0] tok_start;
  logic [LEN_W-1:0]   tok_len;
  logic               is_end;
  logic [1:0]         status;
  logic               last;

  pos_t     lex_pos;
  pos_t     lex_word_len;
  quote_e   lex_quote;
  held_op_e lex_held;
  logic     lex_overflow;

  token_t expected_tokens[$];
  token_t byte_tokens[$];
  token_t want_tok;
  int     fault_count = 0;
  int     idle_cycles = 0;
  pace_e  pace = PH_FREE;

  shell_command_line_lexer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch_ready  (ch_ready),
    .ch        (ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .tok_start (tok_start),
    .tok_len   (tok_len),
    .is_end    (is_end),
    .status    (status),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_lexer();
    lex_pos      = '0;
    lex_word_len = '0;
    lex_quote    = QK_NONE;
    lex_held     = HOLD_NONE;
    lex_overflow = 1'b0;
  endfunction

  function automatic void emit_token(input pos_t start, input pos_t len,
                                     input logic end_flag, input logic [1:0] code);
    token_t t;
    t.tok_start = START_W'(start);
    t.tok_len   = LEN_W'(len);
    t.is_end    = end_flag;
    t.status    = code;
    t.last      = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void flush_word();
    if (lex_word_len != 0) begin
      emit_token(lex_pos - lex_word_len, lex_word_len, 1'b0, ST_OK);
      lex_word_len = '0;
    end
  endfunction

  function automatic void flush_held();
    if (lex_held != HOLD_NONE) begin
      emit_token(lex_pos - 1'b1, pos_t'(1), 1'b0, ST_OK);
      lex_held = HOLD_NONE;
    end
  endfunction

  // tokens caused by one byte, left in byte_tokens
  function automatic void lex_byte(input logic [7:0] c);
    logic [1:0] code;
    logic       paired;
    byte_tokens.delete();
    if (c == CH_NUL) begin
      code = ST_OK;
      flush_held();
      if (lex_quote != QK_NONE) code = ST_QUOTE;
      else flush_word();
      if (lex_overflow) code = ST_LONG;
      emit_token('0, '0, 1'b1, code);
      clear_lexer();
    end else if (lex_pos >= MAX_LINE) begin
      lex_overflow = 1'b1;
    end else begin
      paired = 1'b0;
      if (lex_held != HOLD_NONE) begin
        if ((lex_held == HOLD_LESS && c == CH_LESS) ||
            (lex_held == HOLD_GREAT && c == CH_GREAT)) begin
          emit_token(lex_pos - 1'b1, pos_t'(2), 1'b0, ST_OK);
          lex_held = HOLD_NONE;
          paired = 1'b1;
        end else begin
          flush_held();
        end
      end
      if (!paired) begin
        if (lex_quote != QK_NONE) begin
          lex_word_len++;
          if ((lex_quote == QK_SINGLE && c == CH_SQUOTE) ||
              (lex_quote == QK_DOUBLE && c == CH_DQUOTE)) lex_quote = QK_NONE;
        end else begin
          case (c)
            CH_SPACE, CH_TAB: flush_word();
            CH_PIPE: begin
              flush_word();
              emit_token(lex_pos, pos_t'(1), 1'b0, ST_OK);
            end
            CH_LESS, CH_GREAT: begin
              flush_word();
              lex_held = (c == CH_LESS) ? HOLD_LESS : HOLD_GREAT;
            end
            CH_SQUOTE: begin
              lex_word_len++;
              lex_quote = QK_SINGLE;
            end
            CH_DQUOTE: begin
              lex_word_len++;
              lex_quote = QK_DOUBLE;
            end
            default: lex_word_len++;
          endcase
        end
      end
      lex_pos++;
    end
    if (byte_tokens.size() != 0) byte_tokens[$].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    if ($urandom_range(0, 9) < 7) return 8'(8'h61 + $urandom_range(0, 25));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input logic [1:0] code = ST_OK);
    token_t t;
    while ((pace == PH_SEND_IDLE && $urandom_range(0, 99) < 71) ||
           (pace == PH_BOTH && $urandom_range(0, 99) < 31)) begin
      ch_valid <= 1'b0;
      @(posedge clk);
    end
    ch_valid <= 1'b1;
    ch       <= b;
    do @(posedge clk); while (!ch_ready);
    lex_byte(b);
    if (typed) begin
      t = '{tok_start: '0, tok_len: '0, is_end: 1'b1, status: code, last: 1'b1};
      expected_tokens.push_back(t);
    end else begin
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    end
  endtask

  task automatic await_drain();
    ch_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    case (pace)
      PH_RECV_STALL: res_ready <= ($urandom_range(0, 99) >= 71);
      PH_BOTH:       res_ready <= ($urandom_range(0, 99) >= 31);
      default:       res_ready <= 1'b1;
    endcase
    if (!rst && res_valid && res_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected transaction: tok_start %0d tok_len %0d is_end %0b status %0d",
               tok_start, tok_len, is_end, status);
        fault_count++;
      end else begin
        want_tok = expected_tokens.pop_front();
        if (tok_start !== want_tok.tok_start) begin
          $error("tok_start: expected %0d, got %0d", want_tok.tok_start, tok_start);
          fault_count++;
        end
        if (tok_len !== want_tok.tok_len) begin
          $error("tok_len: expected %0d, got %0d", want_tok.tok_len, tok_len);
          fault_count++;
        end
        if (is_end !== want_tok.is_end) begin
          $error("is_end: expected %0b, got %0b", want_tok.is_end, is_end);
          fault_count++;
        end
        if (status !== want_tok.status) begin
          $error("status: expected %0d, got %0d", want_tok.status, status);
          fault_count++;
        end
        if (last !== want_tok.last) begin
          $error("last: expected %0b, got %0b", want_tok.last, last);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ch_valid && ch_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] line[$];
    logic [7:0] q;
    int         sent;
    clear_lexer();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_byte(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].status);
    await_drain();

    for (int p = 0; p < 4; p++) begin
      pace = pace_e'(p);
      sent = 0;
      while (sent < RANDOM_BYTES / 4) begin
        line.delete();
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 5)) line.push_back(rand_text_byte());
            3: repeat ($urandom_range(1, 3))
                 line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            4: line.push_back(CH_PIPE);
            5: begin
              line.push_back($urandom_range(0, 1) ? CH_LESS : CH_GREAT);
              if ($urandom_range(0, 1)) line.push_back($urandom_range(0, 1) ? CH_LESS : CH_GREAT);
            end
            6, 7: begin
              q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
              line.push_back(q);
              repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 3))
                  0: line.push_back(CH_SPACE);
                  1: line.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
                  default: line.push_back(rand_text_byte());
                endcase
              end
              line.push_back(q);
            end
            8: line.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
            default: line.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        foreach (line[i]) send_byte(line[i]);
        send_byte(CH_NUL);
        sent += line.size() + 1;
        if ($urandom_range(0, 7) == 0) await_drain();
      end
      await_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/slcl_pkg.sv
design/slcl_queue.sv
design/slcl_front.sv
design/slcl_back.sv
design/shell_command_line_lexer_unit.sv
design/slcl_checker.sv
sim/tb_top.sv
